// ===== hdl/steq_pkg.sv =====
// ----------------------------------------------------------------------------
// steq_pkg : shared codes and types of the sorted timer event queue
// Operation and status codes, plus the command and status bundles passed
// between the controller and the slot datapath.
// ----------------------------------------------------------------------------
package steq_pkg;

  // Operation codes of a request (any other code is a plain query)
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       capture;    // latch the request fields
    logic       do_insert;  // place the latched event into the slot chain
    logic       do_pop;     // drop the head and move all slots up
    logic       report;     // load the result registers
    logic [1:0] status;     // status code to report
  } steq_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full;
    logic empty;
  } steq_stat_t;

endpackage

// ===== hdl/steq_ctrl.sv =====
// ----------------------------------------------------------------------------
// steq_ctrl : request controller
// Takes a request, decodes its operation against the queue status and issues
// one execute command, then strobes the result for one cycle.
// ----------------------------------------------------------------------------
module steq_ctrl
  import steq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_op,
  input  steq_stat_t stat,
  output logic       busy,
  output logic       out_valid,
  output steq_cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic       state_r, state_nxt;
  logic [1:0] op_r;
  logic       out_valid_r;
  logic       accept;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // Decode the held operation into datapath commands
  always_comb begin
    cmd           = '0;
    cmd.capture   = accept;
    cmd.report    = (state_r == ST_EXEC);
    cmd.status    = STAT_OK;
    if (state_r == ST_EXEC) begin
      case (op_r)
        OP_INSERT: begin
          if (stat.full) begin
            cmd.status = STAT_FULL;
          end else begin
            cmd.do_insert = 1'b1;
          end
        end
        OP_POP: begin
          if (stat.empty) begin
            cmd.status = STAT_EMPTY;
          end else begin
            cmd.do_pop = 1'b1;
          end
        end
        default: begin
          cmd.status = STAT_OK;
        end
      endcase
    end
  end

  // Advance the state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.report;
    end
  end

  // Hold the operation of the accepted request
  always_ff @(posedge clk) begin
    if (accept) op_r <= in_op;
  end

  assign out_valid = out_valid_r;

  a_exec_reports: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |=> out_valid_r)
    else $error("execute cycle not followed by a result strobe");

  a_strobe_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_EXEC))
    else $error("result strobe without an execute cycle");

  a_accept_executes: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_EXEC))
    else $error("accepted request did not execute");

  a_single_action: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.do_insert && cmd.do_pop))
    else $error("insert and pop issued together");

endmodule

// ===== hdl/steq_datapath.sv =====
// ----------------------------------------------------------------------------
// steq_datapath : slot chain and result registers
// A chain of event cells kept in launch-time order, head in cell 0. Every cell
// compares its key with the new event at once; an insert shifts the cells from
// the insert point down by one, a pop shifts all cells up by one.
// ----------------------------------------------------------------------------
module steq_datapath
  import steq_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int KEY_W = 32,
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  steq_cmd_t        cmd,
  input  logic [31:0]      in_created_at,
  input  logic [31:0]      in_fire_at,
  input  logic [31:0]      in_wait_amount,
  input  logic [31:0]      in_payload,
  output steq_stat_t       stat,
  output logic [31:0]      out_head_fire_at,
  output logic [31:0]      out_head_wait,
  output logic [31:0]      out_head_payload,
  output logic [CNT_W-1:0] out_count,
  output logic             out_is_empty,
  output logic             out_went_to_head,
  output logic [1:0]       out_status
);

  // Latched request fields
  logic [KEY_W-1:0] fire_q_r;
  logic [KEY_W-1:0] created_q_r;
  logic [31:0]      wait_q_r;
  logic [31:0]      pay_q_r;

  // Event cells
  logic [KEY_W-1:0] key_r     [DEPTH];
  logic [KEY_W-1:0] created_r [DEPTH];
  logic [31:0]      wait_r    [DEPTH];
  logic [31:0]      pay_r     [DEPTH];

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [DEPTH-1:0] at_after;   // cell sits at or past the insert point

  // Result registers
  logic [31:0]      head_fire_r;
  logic [31:0]      head_wait_r;
  logic [31:0]      head_pay_r;
  logic [CNT_W-1:0] res_count_r;
  logic             empty_r;
  logic             to_head_r;
  logic [1:0]       status_r;

  logic [KEY_W-1:0] head_key_nxt;
  logic [31:0]      head_wait_nxt;
  logic [31:0]      head_pay_nxt;

  // Latch the request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      fire_q_r    <= in_fire_at[KEY_W-1:0];
      created_q_r <= in_created_at[KEY_W-1:0];
      wait_q_r    <= in_wait_amount;
      pay_q_r     <= in_payload;
    end
  end

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);

  // Compare every cell with the new key; the chain is sorted, so the flags
  // rise once and stay set towards the tail
  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      assign at_after[gi] = (CNT_W'(gi) >= count_r) || (fire_q_r <= key_r[gi]);

      if (gi == 0) begin : g_head
        always_ff @(posedge clk) begin
          if (cmd.do_insert && at_after[0]) begin
            key_r[0]     <= fire_q_r;
            created_r[0] <= created_q_r;
            wait_r[0]    <= wait_q_r;
            pay_r[0]     <= pay_q_r;
          end else if (cmd.do_pop) begin
            key_r[0]     <= key_r[1];
            created_r[0] <= created_r[1];
            wait_r[0]    <= wait_r[1];
            pay_r[0]     <= pay_r[1];
          end
        end
      end else begin : g_body
        always_ff @(posedge clk) begin
          if (cmd.do_insert && at_after[gi]) begin
            if (!at_after[gi-1]) begin
              key_r[gi]     <= fire_q_r;
              created_r[gi] <= created_q_r;
              wait_r[gi]    <= wait_q_r;
              pay_r[gi]     <= pay_q_r;
            end else begin
              key_r[gi]     <= key_r[gi-1];
              created_r[gi] <= created_r[gi-1];
              wait_r[gi]    <= wait_r[gi-1];
              pay_r[gi]     <= pay_r[gi-1];
            end
          end else if (cmd.do_pop && (gi < DEPTH - 1)) begin
            key_r[gi]     <= key_r[(gi + 1) % DEPTH];
            created_r[gi] <= created_r[(gi + 1) % DEPTH];
            wait_r[gi]    <= wait_r[(gi + 1) % DEPTH];
            pay_r[gi]     <= pay_r[(gi + 1) % DEPTH];
          end
        end
      end
    end
  endgenerate

  // Track the number of stored events
  always_comb begin
    count_nxt = count_r;
    if (cmd.do_insert) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Select the head as it stands after this request
  always_comb begin
    head_key_nxt  = key_r[0];
    head_wait_nxt = wait_r[0];
    head_pay_nxt  = pay_r[0];
    if (cmd.do_insert && at_after[0]) begin
      head_key_nxt  = fire_q_r;
      head_wait_nxt = wait_q_r;
      head_pay_nxt  = pay_q_r;
    end else if (cmd.do_pop) begin
      head_key_nxt  = key_r[1];
      head_wait_nxt = wait_r[1];
      head_pay_nxt  = pay_r[1];
    end
  end

  // Load the result; an empty queue reports a zero head
  always_ff @(posedge clk) begin
    if (cmd.report) begin
      if (count_nxt == '0) begin
        head_fire_r <= '0;
        head_wait_r <= '0;
        head_pay_r  <= '0;
      end else begin
        head_fire_r <= 32'(head_key_nxt);
        head_wait_r <= head_wait_nxt;
        head_pay_r  <= head_pay_nxt;
      end
      res_count_r <= count_nxt;
      empty_r     <= (count_nxt == '0);
      to_head_r   <= cmd.do_insert && at_after[0];
      status_r    <= cmd.status;
    end
  end

  assign out_head_fire_at = head_fire_r;
  assign out_head_wait    = head_wait_r;
  assign out_head_payload = head_pay_r;
  assign out_count        = res_count_r;
  assign out_is_empty     = empty_r;
  assign out_went_to_head = to_head_r;
  assign out_status       = status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("event count above queue depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_insert |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not add one event");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_pop |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("pop did not remove one event");

  a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_insert |-> !stat.full)
    else $error("insert into a full queue");

endmodule

// ===== hdl/sorted_timer_event_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_timer_event_queue : bounded timer event queue ordered by launch time
// Holds up to QUEUE_DEPTH events, earliest launch time at the head. A request
// inserts an event, pops the head or only queries; each request returns the
// head, the count, whether an insert became the head, and a status code.
//
//   channel   ports                          handshake
//   request   in_op, in_created_at,          taken when start && !busy
//             in_fire_at, in_wait_amount,
//             in_payload
//   result    out_head_*, out_count,         one-cycle strobe out_valid,
//             out_is_empty, out_went_to_head,  cannot be held off
//             out_status
//
// A request is latched when taken; then, in the execute state, every slot cell
// compares and shifts at once. The result strobes in the cycle after that,
// while the next request may already be taken. busy is high for one cycle
// after each accepted request. Reset clears the event count and the control
// state; slots and results are not cleared. The result side never stalls.
// ----------------------------------------------------------------------------
module sorted_timer_event_queue
  import steq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 32,
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_op,
  input  logic [31:0]      in_created_at,
  input  logic [31:0]      in_fire_at,
  input  logic [31:0]      in_wait_amount,
  input  logic [31:0]      in_payload,
  output logic             out_valid,
  output logic [31:0]      out_head_fire_at,
  output logic [31:0]      out_head_wait,
  output logic [31:0]      out_head_payload,
  output logic [CNT_W-1:0] out_count,
  output logic             out_is_empty,
  output logic             out_went_to_head,
  output logic [1:0]       out_status
);

  // Times are kept in their low TIME_BITS bits, at most the port width
  localparam int KEY_W = (TIME_BITS < 32) ? TIME_BITS : 32;

  steq_cmd_t  cmd;
  steq_stat_t stat;

  steq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_op     (in_op),
    .stat      (stat),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  steq_datapath #(
    .DEPTH (QUEUE_DEPTH),
    .KEY_W (KEY_W),
    .CNT_W (CNT_W)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_created_at    (in_created_at),
    .in_fire_at       (in_fire_at),
    .in_wait_amount   (in_wait_amount),
    .in_payload       (in_payload),
    .stat             (stat),
    .out_head_fire_at (out_head_fire_at),
    .out_head_wait    (out_head_wait),
    .out_head_payload (out_head_payload),
    .out_count        (out_count),
    .out_is_empty     (out_is_empty),
    .out_went_to_head (out_went_to_head),
    .out_status       (out_status)
  );

endmodule

// ===== tb/sv/sorted_timer_event_queue_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_timer_event_queue_tb : self-checking bench of the timer event queue
// Feeds insert, pop and query requests through the start/busy handshake in
// random bursts and gaps, and keeps a slot-by-slot model of the sorted queue.
// Each strobed report is checked field by field against the model's answer.
// ----------------------------------------------------------------------------
module sorted_timer_event_queue_tb
  import steq_pkg::*;
();

  localparam int QUEUE_DEPTH  = 16;
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int RANDOM_ITEMS = 600;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 200000;

  // Codes without a name in the package
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] created_at;
    logic [31:0] fire_at;
    logic [31:0] wait_amount;
    logic [31:0] payload;
  } request_t;

  typedef struct {
    logic [31:0] created_at;
    logic [31:0] fire_at;
    logic [31:0] wait_amount;
    logic [31:0] payload;
  } timer_event_t;

  typedef struct {
    logic [31:0] head_fire_at;
    logic [31:0] head_wait;
    logic [31:0] head_payload;
    logic [4:0]  count;
    logic        is_empty;
    logic        went_to_head;
    logic [1:0]  status;
  } head_report_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       in_op = OP_QUERY;
  logic [31:0]      in_created_at = '0;
  logic [31:0]      in_fire_at = '0;
  logic [31:0]      in_wait_amount = '0;
  logic [31:0]      in_payload = '0;
  logic             out_valid;
  logic [31:0]      out_head_fire_at;
  logic [31:0]      out_head_wait;
  logic [31:0]      out_head_payload;
  logic [CNT_W-1:0] out_count;
  logic             out_is_empty;
  logic             out_went_to_head;
  logic [1:0]       out_status;

  request_t     pending_requests[$];
  head_report_t expected_reports[$];

  // Model of the slot chain
  timer_event_t model_slots[QUEUE_DEPTH];
  int           model_count = 0;

  int error_count     = 0;
  int accepted_count  = 0;
  int checked_count   = 0;
  int refused_inserts = 0;
  int empty_pops      = 0;
  int head_inserts    = 0;
  int peak_count      = 0;
  int cycle_count     = 0;
  int burst_left      = 4;
  int gap_left        = 0;

  request_t     taken_request;
  head_report_t taken_report;
  head_report_t seen_report;

  sorted_timer_event_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TIME_BITS  (32)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_created_at   (in_created_at),
    .in_fire_at      (in_fire_at),
    .in_wait_amount  (in_wait_amount),
    .in_payload      (in_payload),
    .out_valid       (out_valid),
    .out_head_fire_at(out_head_fire_at),
    .out_head_wait   (out_head_wait),
    .out_head_payload(out_head_payload),
    .out_count       (out_count),
    .out_is_empty    (out_is_empty),
    .out_went_to_head(out_went_to_head),
    .out_status      (out_status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one request to the model and return the head report it gives
  function automatic head_report_t apply_request(request_t rq);
    head_report_t rp;
    int           pos;
    int           k;
    rp = '{default: '0};
    rp.status = STAT_OK;
    if (rq.op == OP_INSERT) begin
      if (model_count >= QUEUE_DEPTH) begin
        rp.status = STAT_FULL;
      end else begin
        // place ahead of the first event that does not fire earlier
        pos = 0;
        while (pos < model_count && rq.fire_at > model_slots[pos].fire_at) pos++;
        for (k = model_count; k > pos; k--) model_slots[k] = model_slots[k-1];
        model_slots[pos] = '{rq.created_at, rq.fire_at, rq.wait_amount, rq.payload};
        model_count++;
        rp.went_to_head = (pos == 0);
      end
    end else if (rq.op == OP_POP) begin
      if (model_count == 0) begin
        rp.status = STAT_EMPTY;
      end else begin
        for (k = 1; k < model_count; k++) model_slots[k-1] = model_slots[k];
        model_count--;
      end
    end
    rp.count = model_count[4:0];
    rp.is_empty = (model_count == 0);
    if (model_count != 0) begin
      rp.head_fire_at = model_slots[0].fire_at;
      rp.head_wait    = model_slots[0].wait_amount;
      rp.head_payload = model_slots[0].payload;
    end
    return rp;
  endfunction

  function automatic request_t make_request(logic [1:0] op, logic [31:0] created,
                                            logic [31:0] fire, logic [31:0] dly,
                                            logic [31:0] handle);
    request_t rq;
    rq.op          = op;
    rq.created_at  = created;
    rq.fire_at     = fire;
    rq.wait_amount = dly;
    rq.payload     = handle;
    return rq;
  endfunction

  // Launch times: many small values for ties, some extremes, the rest anywhere
  function automatic logic [31:0] pick_fire_at();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 32'($urandom_range(0, 15));
    if (roll < 48) return 32'h0000_0000;
    if (roll < 56) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // Drive requests from the pending list in bursts with gaps between them
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        taken_request = pending_requests.pop_front();
        taken_report  = apply_request(taken_request);
        expected_reports.push_back(taken_report);
        accepted_count++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 5);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        start          <= 1'b1;
        in_op          <= pending_requests[0].op;
        in_created_at  <= pending_requests[0].created_at;
        in_fire_at     <= pending_requests[0].fire_at;
        in_wait_amount <= pending_requests[0].wait_amount;
        in_payload     <= pending_requests[0].payload;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Check each strobed report against the oldest expected one
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: report with none expected, expected nothing actual count %0d",
                 $time, out_count);
        error_count++;
      end else begin
        seen_report = expected_reports.pop_front();
        check_field("head_fire_at", seen_report.head_fire_at, out_head_fire_at);
        check_field("head_wait", seen_report.head_wait, out_head_wait);
        check_field("head_payload", seen_report.head_payload, out_head_payload);
        check_field("count", 32'(seen_report.count), 32'(out_count));
        check_field("is_empty", 32'(seen_report.is_empty), 32'(out_is_empty));
        check_field("went_to_head", 32'(seen_report.went_to_head), 32'(out_went_to_head));
        check_field("status", 32'(seen_report.status), 32'(out_status));
        checked_count++;
        if (seen_report.status == STAT_FULL) refused_inserts++;
        if (seen_report.status == STAT_EMPTY) empty_pops++;
        if (seen_report.went_to_head) head_inserts++;
        if (int'(seen_report.count) > peak_count) peak_count = int'(seen_report.count);
      end
    end
  end

  // Hold a cycle budget over the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sorted_timer_event_queue_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int made;
    int seg_len;
    int insert_pct;
    int roll;
    logic [1:0] op;

    // Directed: empty-queue cases, extremes, ties, middle insert, drain
    pending_requests.push_back(make_request(OP_POP, '1, '1, '1, '1));
    pending_requests.push_back(make_request(OP_QUERY, '0, '0, '0, '0));
    pending_requests.push_back(make_request(OP_SPARE, '1, '1, '1, '1));
    pending_requests.push_back(make_request(OP_INSERT, '0, '1, '1, '0));
    pending_requests.push_back(make_request(OP_INSERT, '1, '0, '0, '1));
    pending_requests.push_back(make_request(OP_INSERT, 32'h5A5A_5A5A, '0,
                                            32'h1234_5678, 32'hA5A5_A5A5));
    pending_requests.push_back(make_request(OP_INSERT, 32'h0F0F_0F0F, '1,
                                            32'h8765_4321, 32'hF0F0_F0F0));
    pending_requests.push_back(make_request(OP_INSERT, 32'h0000_0001, 32'h8000_0000,
                                            32'h0000_0002, 32'h0000_0003));
    pending_requests.push_back(make_request(OP_QUERY, '1, '1, '1, '1));
    pending_requests.push_back(make_request(OP_SPARE, '0, '0, '0, '0));
    repeat (6) pending_requests.push_back(make_request(OP_POP, '0, '0, '0, '0));
    pending_requests.push_back(make_request(OP_INSERT, 32'h1, 32'h7, 32'h9, 32'hB));
    pending_requests.push_back(make_request(OP_INSERT, 32'h2, 32'h7, 32'hA, 32'hC));
    pending_requests.push_back(make_request(OP_INSERT, 32'h3, 32'h6, 32'hB, 32'hD));

    // Random: segments leaning to inserts, to pops, or balanced, so the
    // queue swings between empty and full
    made = 0;
    while (made < RANDOM_ITEMS) begin
      seg_len = $urandom_range(20, 60);
      roll = $urandom_range(0, 2);
      insert_pct = (roll == 0) ? 85 : (roll == 1) ? 50 : 15;
      repeat (seg_len) begin
        roll = $urandom_range(0, 99);
        if (roll < insert_pct) op = OP_INSERT;
        else if (roll < 92) op = OP_POP;
        else if (roll < 97) op = OP_QUERY;
        else op = OP_SPARE;
        pending_requests.push_back(make_request(op, $urandom, pick_fire_at(),
                                                $urandom, $urandom));
        made++;
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: wait for every request and report, then let the pipeline settle
    while (pending_requests.size() != 0 || expected_reports.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (expected_reports.size() != 0) begin
      $display("%0t: reports missing, expected %0d more actual 0", $time,
               expected_reports.size());
      error_count++;
    end
    $display("Covered %0d requests, %0d reports checked, peak depth %0d of %0d.",
             accepted_count, checked_count, peak_count, QUEUE_DEPTH);
    $display("Saw %0d refused inserts, %0d pops on empty, %0d inserts to head.",
             refused_inserts, empty_pops, head_inserts);
    if (error_count == 0) begin
      $display("sorted_timer_event_queue_tb: done, clean");
    end else begin
      $display("sorted_timer_event_queue_tb: done, errors");
    end
    $finish;
  end

endmodule
